[rtl/core/rc4rf_pkg.sv]
package rc4rf_pkg;

   localparam int BYTE_W        = 8;
   localparam int BOX_DEPTH     = 256;
   localparam int BOX_AW        = 8;
   localparam int KEY_INDEX_W   = 6;
   localparam int KEY_BYTES_DEF = 64;
   localparam int ROT_W         = 3;

   typedef enum logic [1:0] {
      ACT_LOAD_KEY = 2'd0,
      ACT_SCHEDULE = 2'd1,
      ACT_RESTART  = 2'd2,
      ACT_DATA     = 2'd3
   } action_type;

   function automatic logic [BYTE_W-1:0] rotl8(input logic [BYTE_W-1:0] x,
                                               input logic [ROT_W-1:0] r);
      logic [2*BYTE_W-1:0] t;
      t = {x, x} << r;
      return t[2*BYTE_W-1:BYTE_W];
   endfunction

   function automatic logic [BYTE_W-1:0] rotr8(input logic [BYTE_W-1:0] x,
                                               input logic [ROT_W-1:0] r);
      logic [2*BYTE_W-1:0] t;
      t = {x, x} >> r;
      return t[BYTE_W-1:0];
   endfunction

endpackage

[rtl/core/rc4_rotate_feedback_cipher.sv]
// Channel | Direction | Handshake            | Payload
// csr     | in        | csr_valid/csr_ready  | csr_direction
// req     | in        | req_valid/req_stall  | req_action, req_key_index, req_key_byte,
//         |           |                      | req_data_byte
// rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte
//
// Key loads and restarts finish when accepted. A data request passes the accept
// state plus four box-memory states (read S[i], read S[j], swap with key read, swap).
// The first data request after a restart first copies the initial box.
// A schedule request fills the initial box, then runs four step states per entry.
// Reset clears the indices, the started flag, the direction and the response slot.
// A pending response does not block new requests; only a second result waits.
module rc4_rotate_feedback_cipher
   import rc4rf_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_direction,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic [KEY_INDEX_W-1:0] req_key_index,
   input  logic [BYTE_W-1:0]      req_key_byte,
   input  logic [BYTE_W-1:0]      req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BYTE_W-1:0]      rsp_out_byte
);

   localparam int KEY_AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCH_FILL,
      ST_SCH_RD_A,
      ST_SCH_RD_B,
      ST_SCH_WR_N,
      ST_SCH_WR_J,
      ST_COPY,
      ST_COPY_LAST,
      ST_D_RD_I,
      ST_D_RD_J,
      ST_D_SWAP_I,
      ST_D_SWAP_J
   } state_type;

   state_type           state_ff, state_in;
   logic [BOX_AW-1:0]   n_ff, n_in;
   logic [KEY_AW-1:0]   kp_ff, kp_in;
   logic [BYTE_W-1:0]   sch_j_ff, sch_j_in;
   logic [BYTE_W-1:0]   a_ff, a_in;
   logic [BYTE_W-1:0]   b_ff, b_in;
   logic [BYTE_W-1:0]   i_ff, i_in;
   logic [BYTE_W-1:0]   j_ff, j_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic [BYTE_W-1:0]   out_ff, out_in;
   logic                started_ff, started_in;
   logic                dir_ff, dir_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                key_we;
   logic [KEY_AW-1:0]   key_waddr;
   logic [BYTE_W-1:0]   key_rdata;
   logic                init_we;
   logic [BOX_AW-1:0]   init_waddr, init_raddr;
   logic [BYTE_W-1:0]   init_wdata, init_rdata;
   logic                work_we;
   logic [BOX_AW-1:0]   work_waddr, work_raddr;
   logic [BYTE_W-1:0]   work_wdata, work_rdata;
   logic                box_we;
   logic                box_rd_work;
   logic [BOX_AW:0]     box_waddr, box_raddr;
   logic [BYTE_W-1:0]   box_wdata, box_rdata;

   logic                req_fire;
   logic                rsp_free;
   logic                key_in_range;
   logic [BYTE_W-1:0]   sch_jn;
   logic [BYTE_W-1:0]   sum_ab;
   logic [BYTE_W-1:0]   k_byte;
   logic [BYTE_W-1:0]   enc_byte;
   logic [BYTE_W-1:0]   dec_byte;

   rc4rf_ram #(.DEPTH(KEY_BYTES), .AW(KEY_AW)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (req_key_byte),
      .rd_addr (kp_ff),
      .rd_data (key_rdata)
   );

   // The initial box sits in the lower half and the working box in the upper half.
   rc4rf_ram #(.DEPTH(2 * BOX_DEPTH), .AW(BOX_AW + 1)) u_box_ram (
      .clock   (clock),
      .wr_en   (box_we),
      .wr_addr (box_waddr),
      .wr_data (box_wdata),
      .rd_addr (box_raddr),
      .rd_data (box_rdata)
   );

   assign box_rd_work = state_ff inside {ST_D_RD_I, ST_D_RD_J, ST_D_SWAP_I, ST_D_SWAP_J};
   assign box_raddr   = box_rd_work ? {1'b1, work_raddr} : {1'b0, init_raddr};
   assign box_we      = init_we || work_we;
   assign box_waddr   = work_we ? {1'b1, work_waddr} : {1'b0, init_waddr};
   assign box_wdata   = work_we ? work_wdata : init_wdata;
   assign init_rdata  = box_rdata;
   assign work_rdata  = box_rdata;

   assign csr_ready    = 1'b1;
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_fire     = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_ff;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign key_in_range = {{(32-KEY_INDEX_W){1'b0}}, req_key_index} < 32'(KEY_BYTES);
   assign key_waddr    = KEY_AW'(req_key_index);
   assign key_we       = req_fire && (action_type'(req_action) == ACT_LOAD_KEY)
                         && key_in_range;

   assign sch_jn = sch_j_ff + init_rdata + key_rdata;
   assign sum_ab = a_ff + b_ff;

   // The key byte was read while S[i] was being written, so the swapped values are
   // forwarded; S[j] is written last and wins when i and j coincide.
   assign k_byte   = (sum_ab == j_ff) ? a_ff :
                     (sum_ab == i_ff) ? b_ff : work_rdata;
   assign enc_byte = rotl8(data_ff, b_ff[ROT_W-1:0]) ^ k_byte;
   assign dec_byte = rotr8(data_ff ^ k_byte, b_ff[ROT_W-1:0]);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      kp_in        = kp_ff;
      sch_j_in     = sch_j_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      data_in      = data_ff;
      out_in       = out_ff;
      started_in   = started_ff;
      dir_in       = csr_valid ? csr_direction : dir_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      init_we      = 1'b0;
      init_waddr   = n_ff;
      init_wdata   = n_ff;
      init_raddr   = n_ff;
      work_we      = 1'b0;
      work_waddr   = n_ff - 1'b1;
      work_wdata   = init_rdata;
      work_raddr   = i_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               data_in = req_data_byte;
               case (action_type'(req_action))
                  ACT_SCHEDULE: begin
                     n_in     = '0;
                     kp_in    = '0;
                     sch_j_in = '0;
                     state_in = ST_SCH_FILL;
                  end
                  ACT_RESTART: begin
                     started_in = 1'b0;
                  end
                  ACT_DATA: begin
                     if (started_ff) begin
                        state_in = ST_D_RD_I;
                     end else begin
                        n_in       = '0;
                        i_in       = '0;
                        j_in       = '0;
                        started_in = 1'b1;
                        state_in   = ST_COPY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCH_FILL: begin
            init_we = 1'b1;
            n_in    = n_ff + 1'b1;
            if (n_ff == BOX_AW'(BOX_DEPTH - 1)) begin
               state_in = ST_SCH_RD_A;
            end
         end
         ST_SCH_RD_A: begin
            state_in = ST_SCH_RD_B;
         end
         ST_SCH_RD_B: begin
            a_in       = init_rdata;
            sch_j_in   = sch_jn;
            init_raddr = sch_jn;
            state_in   = ST_SCH_WR_N;
         end
         ST_SCH_WR_N: begin
            init_we    = 1'b1;
            init_wdata = init_rdata;
            state_in   = ST_SCH_WR_J;
         end
         ST_SCH_WR_J: begin
            init_we    = 1'b1;
            init_waddr = sch_j_ff;
            init_wdata = a_ff;
            n_in       = n_ff + 1'b1;
            kp_in      = (kp_ff == KEY_AW'(KEY_BYTES - 1)) ? '0 : kp_ff + 1'b1;
            state_in   = (n_ff == BOX_AW'(BOX_DEPTH - 1)) ? ST_IDLE : ST_SCH_RD_A;
         end
         ST_COPY: begin
            // Reads run one entry ahead of the writes into the working box.
            work_we = (n_ff != '0);
            n_in    = n_ff + 1'b1;
            if (n_ff == BOX_AW'(BOX_DEPTH - 1)) begin
               state_in = ST_COPY_LAST;
            end
         end
         ST_COPY_LAST: begin
            work_we  = 1'b1;
            state_in = ST_D_RD_I;
         end
         ST_D_RD_I: begin
            work_raddr = i_ff + 1'b1;
            i_in       = i_ff + 1'b1;
            state_in   = ST_D_RD_J;
         end
         ST_D_RD_J: begin
            a_in       = work_rdata;
            j_in       = j_ff + work_rdata;
            work_raddr = j_ff + work_rdata;
            state_in   = ST_D_SWAP_I;
         end
         ST_D_SWAP_I: begin
            b_in       = work_rdata;
            work_we    = 1'b1;
            work_waddr = i_ff;
            work_wdata = work_rdata;
            work_raddr = a_ff + work_rdata;
            state_in   = ST_D_SWAP_J;
         end
         ST_D_SWAP_J: begin
            work_we    = 1'b1;
            work_waddr = j_ff;
            work_wdata = a_ff;
            work_raddr = sum_ab;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_in       = dir_ff ? dec_byte : enc_byte;
               j_in         = j_ff + (dir_ff ? data_ff : enc_byte);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
      end
      n_ff     <= n_in;
      kp_ff    <= kp_in;
      sch_j_ff <= sch_j_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      data_ff  <= data_in;
      out_ff   <= out_in;
   end

endmodule

[rtl/core/rc4rf_ram.sv]
module rc4rf_ram
   import rc4rf_pkg::*;
#(
   parameter int DEPTH = BOX_DEPTH,
   parameter int AW    = BOX_AW
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Read returns the entry as it was before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/rc4rf_stream_checker.sv]
module rc4rf_stream_checker
   import rc4rf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic                   csr_direction,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  action_type             req_action,
   input  logic [KEY_INDEX_W-1:0] req_key_index,
   input  logic [BYTE_W-1:0]      req_key_byte,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [BYTE_W-1:0]      rsp_out_byte,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [BYTE_W-1:0] key_mem  [KEY_BYTES_DEF];
   logic [BYTE_W-1:0] seed_box [BOX_DEPTH];
   logic [BYTE_W-1:0] run_box  [BOX_DEPTH];
   logic [BYTE_W-1:0] ptr_i;
   logic [BYTE_W-1:0] ptr_j;
   logic              stream_live;
   logic              decrypt_mode;
   logic [BYTE_W-1:0] cipher_q [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic logic [BYTE_W-1:0] spin_left(logic [BYTE_W-1:0] x, logic [ROT_W-1:0] r);
      logic [2*BYTE_W-1:0] w;
      w = {{BYTE_W{1'b0}}, x} << r;
      return w[BYTE_W-1:0] | w[2*BYTE_W-1:BYTE_W];
   endfunction

   function automatic logic [BYTE_W-1:0] spin_right(logic [BYTE_W-1:0] x, logic [ROT_W-1:0] r);
      logic [2*BYTE_W-1:0] w;
      w = {x, {BYTE_W{1'b0}}} >> r;
      return w[2*BYTE_W-1:BYTE_W] | w[BYTE_W-1:0];
   endfunction

   function automatic void build_seed_box();
      logic [BYTE_W-1:0] j;
      logic [BYTE_W-1:0] a;
      j = '0;
      for (int n = 0; n < BOX_DEPTH; n++) seed_box[n] = BYTE_W'(n);
      for (int n = 0; n < BOX_DEPTH; n++) begin
         a = seed_box[n];
         j = j + a + key_mem[n % KEY_BYTES_DEF];
         seed_box[n] = seed_box[j];
         seed_box[j] = a;
      end
   endfunction

   function automatic logic [BYTE_W-1:0] cipher_byte(logic [BYTE_W-1:0] din);
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] k;
      logic [BYTE_W-1:0] res;
      // The first byte of a stream starts from a fresh copy of the scheduled box.
      if (!stream_live) begin
         run_box = seed_box;
         ptr_i = '0;
         ptr_j = '0;
         stream_live = 1'b1;
      end
      ptr_i = ptr_i + 1'b1;
      a = run_box[ptr_i];
      ptr_j = ptr_j + a;
      b = run_box[ptr_j];
      run_box[ptr_i] = b;
      run_box[ptr_j] = a;
      k = run_box[BYTE_W'(a + b)];
      // Both directions feed the ciphertext byte back into j.
      if (!decrypt_mode) begin
         res = spin_left(din, b[ROT_W-1:0]) ^ k;
         ptr_j = ptr_j + res;
      end else begin
         ptr_j = ptr_j + din;
         res = spin_right(din ^ k, b[ROT_W-1:0]);
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      $display("%0t ns: %s: expected %02h, got %02h", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [BYTE_W-1:0] want;
      if (reset) begin
         ptr_i = '0;
         ptr_j = '0;
         stream_live = 1'b0;
         decrypt_mode = 1'b0;
         cipher_q.delete();
      end else begin
         if (csr_valid && csr_ready) decrypt_mode = csr_direction;
         if (req_valid && !req_stall) begin
            case (req_action)
               ACT_LOAD_KEY: begin
                  if (req_key_index < KEY_BYTES_DEF) key_mem[req_key_index] = req_key_byte;
               end
               ACT_SCHEDULE: build_seed_box();
               ACT_RESTART:  stream_live = 1'b0;
               ACT_DATA:     cipher_q.push_back(cipher_byte(req_data_byte));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (cipher_q.size() == 0) begin
               report_mismatch("response with no request waiting", 'x, rsp_out_byte);
            end else begin
               want = cipher_q.pop_front();
               if (rsp_out_byte !== want) report_mismatch("out_byte mismatch", want, rsp_out_byte);
            end
         end
      end
      pending <= cipher_q.size();
   end

endmodule

[sim/rc4_rotate_feedback_cipher_tb.sv]
module rc4_rotate_feedback_cipher_tb
   import rc4rf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES    = 1500;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int NUM_PHASES       = 8;
   localparam int PHASE_ITEMS      = 120;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_direction = 1'b0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   action_type             req_action = ACT_LOAD_KEY;
   logic [KEY_INDEX_W-1:0] req_key_index = '0;
   logic [BYTE_W-1:0]      req_key_byte = '0;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BYTE_W-1:0]      rsp_out_byte;
   int                     fail_count;
   int                     pending;

   int gap_odds = 0;
   int stall_odds = 0;
   bit long_hold_req = 1'b0;
   int items_sent = 0;

   rc4_rotate_feedback_cipher i_dut (.*);

   rc4rf_stream_checker i_checker (.*);

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // Response side: random hold-off bursts, plus one long hold on request.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_request(action_type act, logic [KEY_INDEX_W-1:0] kidx,
                               logic [BYTE_W-1:0] kbyte, logic [BYTE_W-1:0] dbyte);
      if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_key_index <= kidx;
      req_key_byte  <= kbyte;
      req_data_byte <= dbyte;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   task automatic send_data(logic [BYTE_W-1:0] dbyte);
      send_request(ACT_DATA, KEY_INDEX_W'($urandom), BYTE_W'($urandom), dbyte);
   endtask

   task automatic send_control(action_type act);
      send_request(act, KEY_INDEX_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
   endtask

   task automatic send_key(logic [KEY_INDEX_W-1:0] kidx, logic [BYTE_W-1:0] kbyte);
      send_request(ACT_LOAD_KEY, kidx, kbyte, BYTE_W'($urandom));
   endtask

   // A schedule request gives no response, so after the last response the block may
   // still be busy with one; wait out its full length as well.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(logic dir);
      drain_and_settle();
      csr_valid     <= 1'b1;
      csr_direction <= dir;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [BYTE_W-1:0] corner [6];
      int target;
      int pick;
      corner = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_direction(1'b0);
      for (int n = 0; n < KEY_BYTES_DEF; n++) begin
         send_key(KEY_INDEX_W'(n), (n == 0) ? 8'h00 : (n == KEY_BYTES_DEF - 1) ? 8'hFF
                                                    : BYTE_W'($urandom));
      end
      send_control(ACT_SCHEDULE);
      foreach (corner[n]) send_data(corner[n]);
      // A restart starts the stream again from a fresh copy of the scheduled box.
      send_control(ACT_RESTART);
      send_data(8'h00);
      send_data(8'h00);
      // Rekeying mid-stream leaves the running stream alone until the next restart.
      send_key(6'd5, 8'h3C);
      send_control(ACT_SCHEDULE);
      send_data(8'hFF);
      send_control(ACT_RESTART);
      send_data(8'hFF);
      send_control(ACT_RESTART);
      send_control(ACT_RESTART);
      send_data(8'h7E);
      // Switch to decryption without restarting the stream.
      write_direction(1'b1);
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'h5A);
      send_control(ACT_RESTART);
      send_data(8'h00);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_direction((p < 4) ? p[0] : 1'($urandom_range(0, 1)));
         if (p == NUM_PHASES - 1) begin
            gap_odds = 0;
            stall_odds = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: begin gap_odds = 0;  stall_odds = 0;  end
               1: begin gap_odds = 15; stall_odds = 5;  end
               2: begin gap_odds = 35; stall_odds = 15; end
               default: begin gap_odds = 60; stall_odds = 35; end
            endcase
         end
         // Keep offering requests while the response side is held off, so the
         // block backs up and stalls its input.
         if (p == 2) begin
            gap_odds = 0;
            long_hold_req = 1'b1;
         end
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               send_data(BYTE_W'($urandom));
            end else if (pick < 85) begin
               send_key(KEY_INDEX_W'($urandom), BYTE_W'($urandom));
            end else if (pick < 96) begin
               send_control(ACT_RESTART);
            end else if (pick < 99) begin
               repeat ($urandom_range(4, 16)) send_key(KEY_INDEX_W'($urandom), BYTE_W'($urandom));
               send_control(ACT_SCHEDULE);
               send_control(ACT_RESTART);
            end else begin
               send_control(ACT_SCHEDULE);
            end
         end
      end

      drain_and_settle();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
